// ----- hw/rtl/spq2k_pkg.sv -----
package spq2k_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // port widths fixed by the interface
  localparam int TAG_PORT_W = 16;
  localparam int KEY_W      = 8;
  localparam int STAT_W     = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [TAG_BITS-1:0] tag;
    logic [KEY_W-1:0]    age;
    logic [KEY_W-1:0]    pri;
  } slot_t;

  // broadcast to every cell
  typedef struct packed {
    logic                push_en;
    logic                pop_en;
    logic [TAG_BITS-1:0] tag;
    logic [KEY_W-1:0]    age;
    logic [KEY_W-1:0]    pri;
  } cmd_t;

endpackage

// ----- hw/rtl/sorted_priority_queue_two_key_top.sv -----
// result: a request accepted at an edge gives its result on the out_ ports in the
// next cycle, marked by out_strobe for exactly that cycle
// throughput: one request per cycle, busy stays low; every cell compares and shifts
// in the same cycle, so the row of cells sets the rate
// reset: synchronous active-low rst_n clears the cell valid bits and the count, the
// queue comes up empty; the receiver cannot stall results
module sorted_priority_queue_two_key_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_entry_tag,
  input  logic [7:0]  in_age,
  input  logic [7:0]  in_priority_req,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [15:0] out_clash_tag,
  output logic        out_head_valid,
  output logic [15:0] out_head_tag,
  output logic [7:0]  out_head_priority,
  output logic [7:0]  out_head_age,
  output logic [4:0]  out_entry_count
);

  localparam int D = spq2k_pkg::DEPTH;

  spq2k_pkg::cmd_t  cmd;
  spq2k_pkg::slot_t slots [D];
  spq2k_pkg::slot_t empty_slot;
  logic [D-1:0]     ahead_vec;
  logic [D-1:0]     match_vec;
  logic [D-1:0]     valid_vec;

  logic                           accept;
  logic                           is_push, is_pop;
  logic                           dup, full, empty;
  logic [spq2k_pkg::TAG_BITS-1:0] clash;
  logic [spq2k_pkg::STAT_W-1:0]   status;

  logic                           strobe_r;
  logic [spq2k_pkg::STAT_W-1:0]   status_r;
  logic [spq2k_pkg::TAG_BITS-1:0] clash_r;
  logic [spq2k_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  // no multi-cycle work, a request is taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_push = accept && (in_opcode == spq2k_pkg::OP_PUSH);
  assign is_pop  = accept && (in_opcode == spq2k_pkg::OP_POP);

  // keys are unique in the row, so at most one cell matches; or-reduce its tag
  always_comb begin
    clash = '0;
    for (int i = 0; i < D; i++) begin
      clash = clash | (slots[i].tag & {spq2k_pkg::TAG_BITS{match_vec[i]}});
    end
  end

  assign dup   = |match_vec;
  assign full  = slots[D-1].valid;
  assign empty = !slots[0].valid;

  // duplicate check wins over full check
  always_comb begin
    status = spq2k_pkg::ST_OK;
    if (is_push && dup) begin
      status = spq2k_pkg::ST_DUP;
    end else if (is_push && full) begin
      status = spq2k_pkg::ST_FULL;
    end else if (is_pop && empty) begin
      status = spq2k_pkg::ST_EMPTY;
    end
  end

  // request broadcast to the row
  assign cmd.push_en = is_push && !dup && !full;
  assign cmd.pop_en  = is_pop && !empty;
  assign cmd.tag     = in_entry_tag[spq2k_pkg::TAG_BITS-1:0];
  assign cmd.age     = in_age;
  assign cmd.pri     = in_priority_req;

  assign empty_slot = '0;

  // row of cells, slot 0 is the head; push shifts toward the tail, pop toward the head
  for (genvar g = 0; g < D; g++) begin : g_cell
    spq2k_pkg::slot_t prev_s, next_s;
    logic             prev_b;
    if (g == 0) begin : g_first
      assign prev_s = empty_slot;
      assign prev_b = 1'b1;
    end else begin : g_mid
      assign prev_s = slots[g-1];
      assign prev_b = ahead_vec[g-1];
    end
    if (g == D - 1) begin : g_last
      assign next_s = empty_slot;
    end else begin : g_inner
      assign next_s = slots[g+1];
    end

    spq2k_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_slot  (prev_s),
      .prev_ahead (prev_b),
      .next_slot  (next_s),
      .slot       (slots[g]),
      .ahead      (ahead_vec[g]),
      .match      (match_vec[g])
    );

    assign valid_vec[g] = slots[g].valid;
  end

  // entry count tracks the valid prefix
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push_en) begin
      cnt_nxt = cnt_r + spq2k_pkg::CNT_W'(1);
    end else if (cmd.pop_en) begin
      cnt_nxt = cnt_r - spq2k_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      strobe_r <= accept;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status;
    clash_r  <= (status == spq2k_pkg::ST_DUP) ? clash : '0;
  end

  // head comes straight from cell 0, which already holds the updated state
  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_clash_tag     = 16'(clash_r);
  assign out_head_valid    = slots[0].valid;
  assign out_head_tag      = slots[0].valid ? 16'(slots[0].tag) : 16'd0;
  assign out_head_priority = slots[0].valid ? slots[0].pri : 8'd0;
  assign out_head_age      = slots[0].valid ? slots[0].age : 8'd0;
  assign out_entry_count   = 5'(cnt_r);

  // count agrees with the number of valid cells
  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(valid_vec))
    else $error("entry count out of step with cell valid bits");

  // valid cells form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + D'(1))) == '0)
    else $error("valid cells not contiguous from the head");

  // keys held in the row are unique
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one cell matches the pushed keys");

  // every accepted request yields a strobe in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("result strobe missing after accepted request");

endmodule

// ----- hw/rtl/spq2k_cell.sv -----
module spq2k_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq2k_pkg::cmd_t   cmd,
  input  spq2k_pkg::slot_t  prev_slot,
  input  logic              prev_ahead,
  input  spq2k_pkg::slot_t  next_slot,
  output spq2k_pkg::slot_t  slot,
  output logic              ahead,
  output logic              match
);

  logic                          valid_r, valid_nxt;
  logic [spq2k_pkg::TAG_BITS-1:0] tag_r, tag_nxt;
  logic [spq2k_pkg::KEY_W-1:0]    age_r, age_nxt;
  logic [spq2k_pkg::KEY_W-1:0]    pri_r, pri_nxt;

  // held entry ranks ahead of the pushed key
  assign ahead = valid_r && ((pri_r < cmd.pri) || ((pri_r == cmd.pri) && (age_r > cmd.age)));
  assign match = valid_r && (pri_r == cmd.pri) && (age_r == cmd.age);

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    age_nxt   = age_r;
    pri_nxt   = pri_r;
    if (cmd.push_en && !ahead) begin
      if (prev_ahead) begin
        valid_nxt = 1'b1;
        tag_nxt   = cmd.tag;
        age_nxt   = cmd.age;
        pri_nxt   = cmd.pri;
      end else begin
        valid_nxt = prev_slot.valid;
        tag_nxt   = prev_slot.tag;
        age_nxt   = prev_slot.age;
        pri_nxt   = prev_slot.pri;
      end
    end else if (cmd.pop_en) begin
      valid_nxt = next_slot.valid;
      tag_nxt   = next_slot.tag;
      age_nxt   = next_slot.age;
      pri_nxt   = next_slot.pri;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    age_r <= age_nxt;
    pri_r <= pri_nxt;
  end

  assign slot.valid = valid_r;
  assign slot.tag   = tag_r;
  assign slot.age   = age_r;
  assign slot.pri   = pri_r;

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq2k_pkg::*;

  localparam int NUM_ROWS      = 22;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int CALM_FIRST    = 700;   // start of the stretch with no sender gaps
  localparam int CALM_LAST     = 1000;
  localparam int DRAIN_CYCLES  = 4;     // result comes in the cycle after the request

  // one result as the block shows it
  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [TAG_PORT_W-1:0] clash_tag;
    logic                  head_valid;
    logic [TAG_PORT_W-1:0] head_tag;
    logic [KEY_W-1:0]      head_priority;
    logic [KEY_W-1:0]      head_age;
    logic [CNT_W-1:0]      entry_count;
  } queue_view_t;

  // one row of the directed script; typed rows carry their own expected view
  typedef struct packed {
    logic                  op;
    logic [TAG_PORT_W-1:0] tag;
    logic [KEY_W-1:0]      age;
    logic [KEY_W-1:0]      pri;
    logic                  typed;
    queue_view_t           want;
  } script_row_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic        in_opcode        = OP_PUSH;
  logic [15:0] in_entry_tag     = '0;
  logic [7:0]  in_age           = '0;
  logic [7:0]  in_priority_req  = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [15:0] out_clash_tag;
  logic        out_head_valid;
  logic [15:0] out_head_tag;
  logic [7:0]  out_head_priority;
  logic [7:0]  out_head_age;
  logic [4:0]  out_entry_count;

  // sorted copy of what the block holds, slot 0 is the head
  logic [TAG_BITS-1:0] held_tag [DEPTH];
  logic [KEY_W-1:0]    held_age [DEPTH];
  logic [KEY_W-1:0]    held_pri [DEPTH];
  int                  held_n = 0;

  queue_view_t views_due [$];   // expected views, oldest first
  int          mismatches = 0;
  script_row_t script [NUM_ROWS];

  sorted_priority_queue_two_key_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_entry_tag      (in_entry_tag),
    .in_age            (in_age),
    .in_priority_req   (in_priority_req),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_clash_tag     (out_clash_tag),
    .out_head_valid    (out_head_valid),
    .out_head_tag      (out_head_tag),
    .out_head_priority (out_head_priority),
    .out_head_age      (out_head_age),
    .out_entry_count   (out_entry_count)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // apply one request to the sorted copy and return the view it should give
  function automatic queue_view_t queue_update(input logic op, input logic [15:0] tag,
                                               input logic [7:0] age, input logic [7:0] pri);
    queue_view_t v;
    int          pos;
    bit          dup;
    v   = '0;
    pos = 0;
    dup = 1'b0;
    if (op == OP_PUSH) begin
      // held entries are compared until a duplicate is found; the place is just behind the last one ranking earlier
      for (int i = 0; i < held_n && !dup; i++) begin
        if (held_pri[i] == pri && held_age[i] == age) begin
          dup         = 1'b1;
          v.clash_tag = TAG_PORT_W'(held_tag[i]);
        end else if (held_pri[i] < pri || (held_pri[i] == pri && held_age[i] > age)) begin
          pos = i + 1;
        end
      end
      // duplicate wins over full
      if (dup) begin
        v.status = ST_DUP;
      end else if (held_n >= DEPTH) begin
        v.status = ST_FULL;
      end else begin
        v.status = ST_OK;
        for (int i = held_n; i > pos; i--) begin
          held_tag[i] = held_tag[i-1];
          held_age[i] = held_age[i-1];
          held_pri[i] = held_pri[i-1];
        end
        held_tag[pos] = TAG_BITS'(tag);
        held_age[pos] = age;
        held_pri[pos] = pri;
        held_n++;
      end
    end else begin
      if (held_n == 0) begin
        v.status = ST_EMPTY;
      end else begin
        v.status = ST_OK;
        for (int i = 0; i + 1 < held_n; i++) begin
          held_tag[i] = held_tag[i+1];
          held_age[i] = held_age[i+1];
          held_pri[i] = held_pri[i+1];
        end
        held_n--;
      end
    end
    // head fields read as zero on an empty queue
    if (held_n > 0) begin
      v.head_valid    = 1'b1;
      v.head_tag      = TAG_PORT_W'(held_tag[0]);
      v.head_priority = held_pri[0];
      v.head_age      = held_age[0];
    end
    v.entry_count = CNT_W'(held_n);
    return v;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    $display("mismatch in %s: expected %0h, got %0h at %0t", field, want, got, $realtime);
    mismatches++;
  endtask

  // present one request, hold it until accepted, then queue its expected view
  task automatic issue_request(input logic op, input logic [15:0] tag, input logic [7:0] age,
                               input logic [7:0] pri, input bit gaps_on, input bit typed,
                               input queue_view_t typed_view);
    queue_view_t predicted;
    // random sender gaps, with junk on the request fields
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      start           <= 1'b0;
      in_opcode       <= 1'($urandom);
      in_entry_tag    <= 16'($urandom);
      in_age          <= 8'($urandom);
      in_priority_req <= 8'($urandom);
      @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_entry_tag    <= tag;
    in_age          <= age;
    in_priority_req <= pri;
    @(posedge clk);
    // accepted at the first edge with busy low
    while (busy !== 1'b0) @(posedge clk);
    predicted = queue_update(op, tag, age, pri);
    views_due.push_back(typed ? typed_view : predicted);
  endtask

  // result checker: one view per strobe, compared with the oldest expectation
  always @(posedge clk) begin
    queue_view_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (views_due.size() == 0) begin
        flag_mismatch("unrequested result", 32'd0, 32'd1);
      end else begin
        want = views_due.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(out_status));
        if (out_clash_tag !== want.clash_tag)
          flag_mismatch("clash_tag", 32'(want.clash_tag), 32'(out_clash_tag));
        if (out_head_valid !== want.head_valid)
          flag_mismatch("head_valid", 32'(want.head_valid), 32'(out_head_valid));
        if (out_head_tag !== want.head_tag)
          flag_mismatch("head_tag", 32'(want.head_tag), 32'(out_head_tag));
        if (out_head_priority !== want.head_priority)
          flag_mismatch("head_priority", 32'(want.head_priority), 32'(out_head_priority));
        if (out_head_age !== want.head_age)
          flag_mismatch("head_age", 32'(want.head_age), 32'(out_head_age));
        if (out_entry_count !== want.entry_count)
          flag_mismatch("entry_count", 32'(want.entry_count), 32'(out_entry_count));
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] tag;
    logic [7:0]  age;
    logic [7:0]  pri;
    logic        op;
    int          push_pct;
    int          pick;
    int          idx;

    script = '{
      // pop right after reset, queue empty
      '{OP_POP,  16'h0000, 8'd0,   8'd0,   1'b1,
        '{ST_EMPTY, 16'h0000, 1'b0, 16'h0000, 8'd0, 8'd0, 5'd0}},
      // extremes: all-ones tag, oldest age, most urgent priority
      '{OP_PUSH, 16'hFFFF, 8'd255, 8'd0,   1'b1,
        '{ST_OK, 16'h0000, 1'b1, 16'hFFFF, 8'd0, 8'd255, 5'd1}},
      // zero tag, youngest age, least urgent priority lands at the tail
      '{OP_PUSH, 16'h0000, 8'd0,   8'd255, 1'b0, '0},
      // same keys as the head, reports the head's tag
      '{OP_PUSH, 16'h1234, 8'd255, 8'd0,   1'b1,
        '{ST_DUP, 16'hFFFF, 1'b1, 16'hFFFF, 8'd0, 8'd255, 5'd2}},
      // same priority as the head, lower ages settle behind older entries
      '{OP_PUSH, 16'h0A0A, 8'd10,  8'd0,   1'b0, '0},
      '{OP_PUSH, 16'h00C8, 8'd200, 8'd0,   1'b0, '0},
      '{OP_PUSH, 16'h0005, 8'd5,   8'd0,   1'b0, '0},
      // fill the queue with a middle priority
      '{OP_PUSH, 16'h8001, 8'd1,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h8002, 8'd2,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h8003, 8'd3,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h8004, 8'd4,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h8005, 8'd5,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h8006, 8'd6,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h8007, 8'd7,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h8008, 8'd8,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h8009, 8'd9,   8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h800A, 8'd10,  8'd128, 1'b0, '0},
      '{OP_PUSH, 16'h800B, 8'd11,  8'd128, 1'b0, '0},
      // full queue: new keys are dropped
      '{OP_PUSH, 16'h5555, 8'd7,   8'd7,   1'b1,
        '{ST_FULL, 16'h0000, 1'b1, 16'hFFFF, 8'd0, 8'd255, 5'd16}},
      // full queue with a duplicate reports the duplicate
      '{OP_PUSH, 16'hAAAA, 8'd200, 8'd0,   1'b1,
        '{ST_DUP, 16'h00C8, 1'b1, 16'hFFFF, 8'd0, 8'd255, 5'd16}},
      // pops shift the row toward the head
      '{OP_POP,  16'h0000, 8'd0,   8'd0,   1'b0, '0},
      '{OP_POP,  16'h0000, 8'd0,   8'd0,   1'b0, '0}
    };

    // synchronous reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script, no sender gaps
    for (int r = 0; r < NUM_ROWS; r++)
      issue_request(script[r].op, script[r].tag, script[r].age, script[r].pri,
                    1'b0, script[r].typed, script[r].want);

    // random part: phases that lean to filling, churning or draining
    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      op   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      tag  = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 2 && held_n > 0) begin
        // copy the keys of a held entry to force a duplicate
        idx = $urandom_range(0, held_n - 1);
        age = held_age[idx];
        pri = held_pri[idx];
      end else if (pick < 6) begin
        // narrow keys, lots of equal priorities and near misses
        age = 8'($urandom_range(0, 7));
        pri = 8'($urandom_range(0, 3));
      end else begin
        age = 8'($urandom);
        pri = 8'($urandom);
      end
      issue_request(op, tag, age, pri, !(n >= CALM_FIRST && n < CALM_LAST), 1'b0, '0);
    end
    start <= 1'b0;

    // drain, then wait DRAIN_CYCLES quiet cycles to catch stray strobes
    while (views_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #200000;
    $display("testbench failed");
    $finish;
  end

endmodule
